/* rtl/skrt_pkg.sv */
// shared types and constants for the sorted key/record table
// no dependencies; used by skrt_cell, sorted_key_record_table_top and its testbench
package skrt_pkg;

   localparam int CAPACITY_DEF     = 16;
   localparam int KEY_BITS_DEF     = 10;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;
   localparam logic [1:0] MODE_DUMP   = 2'd3;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EXISTS    = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_EMPTY     = 3'd4
   } status_type;

   // what every cell of the row does in a cycle
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_SHIFT
   } cell_cmd_type;

   typedef struct packed {
      logic lt;   // occupied and key below the search key
      logic eq;   // occupied and key equal to the search key
   } cell_flag_type;

endpackage

/* rtl/skrt_cell.sv */
// one slot of the sorted row: holds a key and payload, compares against the
// search key and moves data to or from its neighbors; depends on skrt_pkg
module skrt_cell #(
   parameter int KEY_BITS     = skrt_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = skrt_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                      clock,
   input  skrt_pkg::cell_cmd_type    cmd,
   input  logic                      occupied,
   input  logic [KEY_BITS-1:0]       search_key,
   input  logic [PAYLOAD_BITS-1:0]   new_data,
   input  logic                      left_lt,
   input  logic [KEY_BITS-1:0]       left_key,
   input  logic [PAYLOAD_BITS-1:0]   left_data,
   input  logic [KEY_BITS-1:0]       right_key,
   input  logic [PAYLOAD_BITS-1:0]   right_data,
   output skrt_pkg::cell_flag_type   flag,
   output logic [KEY_BITS-1:0]       key,
   output logic [PAYLOAD_BITS-1:0]   data
);

   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] data_ff, data_in;

   assign flag.lt = occupied && (key_ff < search_key);
   assign flag.eq = occupied && (key_ff == search_key);

   always_comb begin
      key_in  = key_ff;
      data_in = data_ff;
      case (cmd)
         skrt_pkg::CMD_INSERT: begin
            // cells below the slot hold, the slot loads, cells above move up
            if (!flag.lt) begin
               if (left_lt) begin
                  key_in  = search_key;
                  data_in = new_data;
               end else begin
                  key_in  = left_key;
                  data_in = left_data;
               end
            end
         end
         skrt_pkg::CMD_REMOVE: begin
            if (!flag.lt) begin
               key_in  = right_key;
               data_in = right_data;
            end
         end
         skrt_pkg::CMD_SHIFT: begin
            key_in  = right_key;
            data_in = right_data;
         end
         default: begin
            key_in  = key_ff;
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

   assign key  = key_ff;
   assign data = data_ff;

endmodule

/* rtl/sorted_key_record_table_top.sv */
// top level of the sorted key/record table: control sequencer, result
// register and the row of skrt_cell slots; depends on skrt_pkg
//
// sequence: a transaction is taken in idle, then compared and applied in the
//   execute state, where its result is registered
// flow: an insert, delete or lookup is taken, then executed, before the next take;
//   a dump of n records gives one result per cycle while the result is not stalled;
//   a stalled result holds the sequencer until it is taken
// reset: synchronous, clears the record count and control; slot contents
//   are left as they are and never read until written
module sorted_key_record_table_top #(
   parameter int CAPACITY     = skrt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS     = skrt_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = skrt_pkg::PAYLOAD_BITS_DEF,
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_op_mode,
   input  logic [KEY_BITS-1:0]     req_op_key,
   input  logic [PAYLOAD_BITS-1:0] req_op_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [KEY_BITS-1:0]     rsp_rec_key,
   output logic [PAYLOAD_BITS-1:0] rsp_rec_data,
   output logic                    rsp_last_of_run,
   output logic [COUNT_BITS-1:0]   rsp_entry_count
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP
   } state_type;

   state_type                 state_ff;
   logic [1:0]                mode_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [PAYLOAD_BITS-1:0]   data_ff;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [COUNT_BITS-1:0]     remain_ff;

   logic                      rsp_valid_ff;
   skrt_pkg::status_type      rsp_status_ff;
   logic [KEY_BITS-1:0]       rsp_key_ff;
   logic [PAYLOAD_BITS-1:0]   rsp_data_ff;
   logic                      rsp_last_ff;
   logic [COUNT_BITS-1:0]     rsp_count_ff;

   skrt_pkg::cell_cmd_type    cmd;
   skrt_pkg::cell_flag_type   flag   [CAPACITY];
   logic [KEY_BITS-1:0]       c_key  [CAPACITY];
   logic [PAYLOAD_BITS-1:0]   c_data [CAPACITY];

   logic                      out_free;
   logic                      rsp_load;
   logic                      hit;
   logic                      full;
   logic [PAYLOAD_BITS-1:0]   hit_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (count_ff == COUNT_BITS'(CAPACITY));

   // a new result is loaded in every execute or dump step except the start of a non-empty dump
   assign rsp_load = out_free && (state_ff == S_DUMP || (state_ff == S_EXEC &&
                     !(mode_ff == skrt_pkg::MODE_DUMP && count_ff != '0)));

   // at most one cell matches, so an or over the masked payloads selects it
   always_comb begin
      hit      = 1'b0;
      hit_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit      = hit | flag[i].eq;
         hit_data = hit_data | (c_data[i] & {PAYLOAD_BITS{flag[i].eq}});
      end
   end

   always_comb begin
      cmd = skrt_pkg::CMD_HOLD;
      case (state_ff)
         S_EXEC: begin
            if (out_free) begin
               if (mode_ff == skrt_pkg::MODE_INSERT && !hit && !full)
                  cmd = skrt_pkg::CMD_INSERT;
               else if (mode_ff == skrt_pkg::MODE_DELETE && hit)
                  cmd = skrt_pkg::CMD_REMOVE;
            end
         end
         S_DUMP: begin
            if (out_free) cmd = skrt_pkg::CMD_SHIFT;
         end
         default: cmd = skrt_pkg::CMD_HOLD;
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                    left_lt;
         logic [KEY_BITS-1:0]     left_key;
         logic [PAYLOAD_BITS-1:0] left_data;
         logic [KEY_BITS-1:0]     right_key;
         logic [PAYLOAD_BITS-1:0] right_data;

         if (gi == 0) begin : g_first
            assign left_lt   = 1'b1;
            assign left_key  = key_ff;
            assign left_data = data_ff;
         end else begin : g_mid
            assign left_lt   = flag[gi-1].lt;
            assign left_key  = c_key[gi-1];
            assign left_data = c_data[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign right_key  = c_key[gi];
            assign right_data = c_data[gi];
         end else begin : g_inner
            assign right_key  = c_key[gi+1];
            assign right_data = c_data[gi+1];
         end

         skrt_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (COUNT_BITS'(gi) < count_ff),
            .search_key (key_ff),
            .new_data   (data_ff),
            .left_lt    (left_lt),
            .left_key   (left_key),
            .left_data  (left_data),
            .right_key  (right_key),
            .right_data (right_data),
            .flag       (flag[gi]),
            .key        (c_key[gi]),
            .data       (c_data[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_op_mode;
                  key_ff   <= req_op_key;
                  data_ff  <= req_op_data;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  rsp_last_ff <= 1'b1;
                  case (mode_ff)
                     skrt_pkg::MODE_INSERT: begin
                        rsp_key_ff <= key_ff;
                        state_ff   <= S_IDLE;
                        if (hit) begin
                           rsp_status_ff <= skrt_pkg::STATUS_EXISTS;
                           rsp_data_ff   <= hit_data;
                           rsp_count_ff  <= count_ff;
                        end else if (full) begin
                           rsp_status_ff <= skrt_pkg::STATUS_FULL;
                           rsp_data_ff   <= '0;
                           rsp_count_ff  <= count_ff;
                        end else begin
                           rsp_status_ff <= skrt_pkg::STATUS_OK;
                           rsp_data_ff   <= data_ff;
                           rsp_count_ff  <= count_ff + 1'b1;
                           count_ff      <= count_ff + 1'b1;
                        end
                     end
                     skrt_pkg::MODE_DELETE, skrt_pkg::MODE_LOOKUP: begin
                        rsp_key_ff <= key_ff;
                        state_ff   <= S_IDLE;
                        if (hit) begin
                           rsp_status_ff <= skrt_pkg::STATUS_OK;
                           rsp_data_ff   <= hit_data;
                           if (mode_ff == skrt_pkg::MODE_DELETE) begin
                              rsp_count_ff <= count_ff - 1'b1;
                              count_ff     <= count_ff - 1'b1;
                           end else begin
                              rsp_count_ff <= count_ff;
                           end
                        end else begin
                           rsp_status_ff <= skrt_pkg::STATUS_NOT_FOUND;
                           rsp_data_ff   <= '0;
                           rsp_count_ff  <= count_ff;
                        end
                     end
                     default: begin
                        // dump: an empty table answers at once, otherwise the
                        // row is drained through the head cell
                        if (count_ff == '0) begin
                           rsp_status_ff <= skrt_pkg::STATUS_EMPTY;
                           rsp_key_ff    <= '0;
                           rsp_data_ff   <= '0;
                           rsp_count_ff  <= '0;
                           state_ff      <= S_IDLE;
                        end else begin
                           remain_ff <= count_ff;
                           count_ff  <= '0;
                           state_ff  <= S_DUMP;
                        end
                     end
                  endcase
               end
            end
            S_DUMP: begin
               if (out_free) begin
                  rsp_status_ff <= skrt_pkg::STATUS_OK;
                  rsp_key_ff    <= c_key[0];
                  rsp_data_ff   <= c_data[0];
                  rsp_last_ff   <= (remain_ff == COUNT_BITS'(1));
                  rsp_count_ff  <= '0;
                  remain_ff     <= remain_ff - 1'b1;
                  if (remain_ff == COUNT_BITS'(1)) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_rec_key     = rsp_key_ff;
   assign rsp_rec_data    = rsp_data_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("record count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd == skrt_pkg::CMD_INSERT |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not add a record");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd == skrt_pkg::CMD_REMOVE |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not drop a record");

   a_dump_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> count_ff == '0 && remain_ff != '0)
      else $error("dump running with records still counted");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != S_IDLE)
      else $error("result raised without a transaction in work");

endmodule

/* test/sorted_key_record_table_top_tb.sv */
// testbench for sorted_key_record_table_top: insert, delete, lookup and dump
// traffic checked against a behavioral table model; depends on skrt_pkg
module sorted_key_record_table_top_tb;

   localparam int CAP     = skrt_pkg::CAPACITY_DEF;
   localparam int KEY_W   = skrt_pkg::KEY_BITS_DEF;
   localparam int DATA_W  = skrt_pkg::PAYLOAD_BITS_DEF;
   localparam int COUNT_W = $clog2(CAP + 1);
   // about 410 transactions, each at most 16 results behind long random stalls
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      skrt_pkg::status_type status;
      logic [KEY_W-1:0]     key;
      logic [DATA_W-1:0]    data;
      logic                 last;
      logic [COUNT_W-1:0]   count;
   } table_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_op_mode;
   logic [KEY_W-1:0]    req_op_key;
   logic [DATA_W-1:0]   req_op_data;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [2:0]          rsp_status;
   logic [KEY_W-1:0]    rsp_rec_key;
   logic [DATA_W-1:0]   rsp_rec_data;
   logic                rsp_last_of_run;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // table model, kept in ascending key order
   logic [KEY_W-1:0]    model_keys [CAP];
   logic [DATA_W-1:0]   model_data [CAP];
   int                  model_count;
   table_result_type    expected_q [$];

   int                  mismatch_count;
   int                  tx_idle_pct;
   int                  rx_idle_pct;
   int                  cycle_count;

   sorted_key_record_table_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op_mode     (req_op_mode),
      .req_op_key      (req_op_key),
      .req_op_data     (req_op_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_rec_key     (rsp_rec_key),
      .rsp_rec_data    (rsp_rec_data),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_key_record_table_top_tb failed");
      $finish;
   end

   function automatic logic [DATA_W-1:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   function automatic void push_result(skrt_pkg::status_type st, logic [KEY_W-1:0] key,
                                       logic [DATA_W-1:0] data, logic last);
      table_result_type r;
      r.status = st;
      r.key    = key;
      r.data   = data;
      r.last   = last;
      r.count  = COUNT_W'(model_count);
      expected_q.push_back(r);
   endfunction

   // applies one accepted transaction to the model and queues its results
   function automatic void apply_table_op(logic [1:0] mode, logic [KEY_W-1:0] key,
                                          logic [DATA_W-1:0] data);
      int pos;
      int n;
      bit hit;
      logic [DATA_W-1:0] found;
      if (mode == skrt_pkg::MODE_DUMP) begin
         n = model_count;
         if (n == 0) begin
            push_result(skrt_pkg::STATUS_EMPTY, '0, '0, 1'b1);
         end else begin
            model_count = 0;
            for (int i = 0; i < n; i++)
               push_result(skrt_pkg::STATUS_OK, model_keys[i], model_data[i], i == n - 1);
         end
         return;
      end
      pos = 0;
      while (pos < model_count && model_keys[pos] < key) pos++;
      hit = (pos < model_count) && (model_keys[pos] == key);
      if (mode == skrt_pkg::MODE_INSERT) begin
         if (hit) begin
            push_result(skrt_pkg::STATUS_EXISTS, key, model_data[pos], 1'b1);
         end else if (model_count >= CAP) begin
            push_result(skrt_pkg::STATUS_FULL, key, '0, 1'b1);
         end else begin
            for (int i = model_count; i > pos; i--) begin
               model_keys[i] = model_keys[i-1];
               model_data[i] = model_data[i-1];
            end
            model_keys[pos] = key;
            model_data[pos] = data;
            model_count++;
            push_result(skrt_pkg::STATUS_OK, key, data, 1'b1);
         end
      end else if (!hit) begin
         push_result(skrt_pkg::STATUS_NOT_FOUND, key, '0, 1'b1);
      end else begin
         found = model_data[pos];
         if (mode == skrt_pkg::MODE_DELETE) begin
            for (int i = pos; i + 1 < model_count; i++) begin
               model_keys[i] = model_keys[i+1];
               model_data[i] = model_data[i+1];
            end
            model_count--;
         end
         push_result(skrt_pkg::STATUS_OK, key, found, 1'b1);
      end
   endfunction

   // drives one transaction, waits for its handshake, then updates the model
   task automatic send_op(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                          input logic [DATA_W-1:0] data);
      int gap;
      if ($urandom_range(99) < tx_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op_mode <= mode;
      req_op_key  <= key;
      req_op_data <= data;
      do @(posedge clock); while (req_stall !== 1'b0);
      apply_table_op(mode, key, data);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin : take_result
         table_result_type want;
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: status %0d key %0d data %h last %0b count %0d",
                        rsp_status, rsp_rec_key, rsp_rec_data, rsp_last_of_run,
                        rsp_entry_count);
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status || rsp_rec_key !== want.key ||
                rsp_rec_data !== want.data || rsp_last_of_run !== want.last ||
                rsp_entry_count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected status %0d key %0d data %h last %0b count %0d",
                           want.status, want.key, want.data, want.last, want.count);
                  $display("          actual   status %0d key %0d data %h last %0b count %0d",
                           rsp_status, rsp_rec_key, rsp_rec_data, rsp_last_of_run,
                           rsp_entry_count);
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // misses and edge keys on an empty or nearly empty table
   task automatic test_empty_table_and_edges();
      send_op(skrt_pkg::MODE_DUMP, '0, '0);
      send_op(skrt_pkg::MODE_LOOKUP, 10'd5, rand_payload());
      send_op(skrt_pkg::MODE_DELETE, '1, '1);
      send_op(skrt_pkg::MODE_INSERT, '0, '0);
      send_op(skrt_pkg::MODE_INSERT, '1, '1);
      send_op(skrt_pkg::MODE_INSERT, '0, rand_payload());
      send_op(skrt_pkg::MODE_LOOKUP, '1, '0);
      send_op(skrt_pkg::MODE_DELETE, '0, '1);
      send_op(skrt_pkg::MODE_LOOKUP, '0, '0);
      wait_all_results();
   endtask

   // fill every slot, then inserts of the lowest and highest keys while full, and a full dump
   task automatic test_full_table();
      while (model_count < CAP)
         send_op(skrt_pkg::MODE_INSERT, KEY_W'($urandom_range(1, 1022)), rand_payload());
      send_op(skrt_pkg::MODE_INSERT, '0, rand_payload());
      send_op(skrt_pkg::MODE_INSERT, '1, rand_payload());
      send_op(skrt_pkg::MODE_DUMP, KEY_W'($urandom_range(1023)), rand_payload());
      wait_all_results();
   endtask

   function automatic logic [KEY_W-1:0] choose_key();
      int r;
      r = $urandom_range(99);
      if (model_count > 0 && r < 45)
         return model_keys[$urandom_range(model_count - 1)];
      if (r < 65)
         return KEY_W'($urandom_range(15));
      if (r < 70)
         return '1;
      return KEY_W'($urandom_range(1023));
   endfunction

   // random mix weighted toward inserts so the table often fills up
   task automatic test_random_mix(input int tx_pct, input int rx_pct, input int n_items);
      int r;
      logic [1:0] mode;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(99);
         if (r < 48)
            mode = skrt_pkg::MODE_INSERT;
         else if (r < 68)
            mode = skrt_pkg::MODE_DELETE;
         else if (r < 93)
            mode = skrt_pkg::MODE_LOOKUP;
         else
            mode = skrt_pkg::MODE_DUMP;
         send_op(mode, choose_key(), rand_payload());
      end
      wait_all_results();
   endtask

   initial begin
      req_valid      <= 1'b0;
      req_op_mode    <= skrt_pkg::MODE_INSERT;
      req_op_key     <= '0;
      req_op_data    <= '0;
      reset          <= 1'b1;
      model_count    = 0;
      mismatch_count = 0;
      tx_idle_pct    = 31;
      rx_idle_pct    = 61;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_table_and_edges();
      test_full_table();
      test_random_mix(31, 61, 128);
      test_random_mix(61, 31, 128);
      test_random_mix(0, 0, 128);

      // let any stray transaction show up before the verdict
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("sorted_key_record_table_top_tb passed");
      else
         $display("sorted_key_record_table_top_tb failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/skrt_pkg.sv
rtl/skrt_cell.sv
rtl/sorted_key_record_table_top.sv
test/sorted_key_record_table_top_tb.sv
